// ----- rtl/mwpg_pkg.sv -----
`default_nettype none

package mwpg_pkg;

  localparam int MAX_BURST_DEF = 64;
  localparam int SINE_TABLE_BITS_DEF = 8;

  localparam int COUNT_W = 7;
  localparam int SAMPLE_W = 16;
  localparam int ROM_W = 12;
  localparam int ADDR_W = 4;
  localparam int QUEUE_DEPTH = 2;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_WAVEFORM    = 2'd0;
  localparam logic [1:0] REG_PHASE_STEP  = 2'd1;
  localparam logic [1:0] REG_APPLY_SCALE = 2'd2;
  localparam logic [1:0] REG_SCALE_GAIN  = 2'd3;

  // waveform codes, anything else runs as ramp
  localparam logic [1:0] WAVE_SINE   = 2'd0;
  localparam logic [1:0] WAVE_SQUARE = 2'd1;
  localparam logic [1:0] WAVE_RAMP   = 2'd2;

  localparam logic signed [SAMPLE_W-1:0] ONE_Q11 = 16'sd2048;
  localparam logic signed [SAMPLE_W-1:0] GAIN_RESET = 16'sd2048;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                                 64'd156};

  typedef struct packed {
    logic [1:0]                 waveform;
    logic [31:0]                phase_step;
    logic                       apply_scale;
    logic signed [SAMPLE_W-1:0] scale_gain;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic [COUNT_W-1:0] count;
  } req_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  // quarter-wave entry k of a 2^tbits table, Q11, from a Q30 taylor series
  function automatic logic [ROM_W-1:0] sine_entry(input int unsigned k, input int tbits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned sum;
    longint unsigned e;
    x = (HALF_PI_Q30 * longint'(k)) >> tbits;
    x2 = (x * x) >> 30;
    term = x;
    pos = x;
    neg = 64'd0;
    for (int n = 0; n < 6; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n];
      if (n % 2 == 0) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    sum = (pos > neg) ? pos - neg : 64'd0;
    e = (sum * 64'd2048 + (64'd1 << 29)) >> 30;
    if (e > 64'd2048) begin
      e = 64'd2048;
    end
    return e[ROM_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mwpg_cfg.sv -----
`default_nettype none

module mwpg_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mwpg_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  output mwpg_pkg::cfg_t                    cfg
);
  import mwpg_pkg::*;

  logic [1:0] reg_index;
  logic       wr_en;

  assign pready = 1'b1;
  assign reg_index = paddr[3:2];
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.waveform <= WAVE_SINE;
      cfg.phase_step <= '0;
      cfg.apply_scale <= 1'b0;
      cfg.scale_gain <= GAIN_RESET;
    end else if (wr_en) begin
      case (reg_index)
        REG_WAVEFORM:    cfg.waveform <= pwdata[1:0];
        REG_PHASE_STEP:  cfg.phase_step <= pwdata;
        REG_APPLY_SCALE: cfg.apply_scale <= pwdata[0];
        REG_SCALE_GAIN:  cfg.scale_gain <= $signed(pwdata[SAMPLE_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_WAVEFORM:    prdata = {30'd0, cfg.waveform};
      REG_PHASE_STEP:  prdata = cfg.phase_step;
      REG_APPLY_SCALE: prdata = {31'd0, cfg.apply_scale};
      REG_SCALE_GAIN:  prdata = {16'd0, cfg.scale_gain};
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/mwpg_front.sv -----
`default_nettype none

module mwpg_front #(
  parameter int MAX_BURST = mwpg_pkg::MAX_BURST_DEF
) (
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [7:0]                        s_tdata,
  input  wire logic                              queue_full,
  output mwpg_pkg::req_t                         push
);
  import mwpg_pkg::*;

  localparam logic [COUNT_W-1:0] BURST_CAP = COUNT_W'(MAX_BURST);

  logic [COUNT_W-1:0] count_in;

  assign count_in = s_tdata[COUNT_W-1:0];
  assign s_tready = !queue_full;

  // empty requests are swallowed here, oversized ones cut to the cap
  always_comb begin
    push.valid = s_tvalid && s_tready && (count_in != '0);
    push.count = (count_in > BURST_CAP) ? BURST_CAP : count_in;
  end

endmodule

`default_nettype wire

// ----- rtl/mwpg_queue.sv -----
`default_nettype none

module mwpg_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  mwpg_pkg::req_t      push,
  output logic                full,
  input  wire logic           pop,
  output mwpg_pkg::req_t      head
);
  import mwpg_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  logic [COUNT_W-1:0] slots [QUEUE_DEPTH];
  logic [IDX_W-1:0]   wr_ptr;
  logic [IDX_W-1:0]   rd_ptr;
  logic [IDX_W:0]     fill;

  assign full = (fill == (IDX_W+1)'(QUEUE_DEPTH));
  assign head.valid = (fill != '0);
  assign head.count = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push.valid, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mwpg_back.sv -----
`default_nettype none

module mwpg_back #(
  parameter int SINE_TABLE_BITS = mwpg_pkg::SINE_TABLE_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  mwpg_pkg::cfg_t                            cfg,
  input  mwpg_pkg::req_t                            head,
  output logic                                      pop,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  output logic signed [mwpg_pkg::SAMPLE_W-1:0]      m_tdata,
  output logic                                      m_tlast
);
  import mwpg_pkg::*;

  localparam int QUARTER = 1 << SINE_TABLE_BITS;
  localparam int IDX_W = SINE_TABLE_BITS + 1;

  logic [ROM_W-1:0] sine_rom [QUARTER+1];

  for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
    assign sine_rom[k] = sine_entry(k, SINE_TABLE_BITS);
  end

  seq_state_t state;
  seq_state_t state_next;
  logic               pipe_en;
  logic               issue;
  logic [COUNT_W-1:0] left;
  logic [31:0]        phase;

  logic                       s1_valid;
  logic                       s1_last;
  logic [31:0]                s1_phase;
  logic [IDX_W-1:0]           s1_idx;
  logic signed [SAMPLE_W-1:0] s1_other;

  logic                       s2_valid;
  logic                       s2_last;
  logic                       s2_sine;
  logic                       s2_neg;
  logic [ROM_W-1:0]           s2_rom;
  logic signed [SAMPLE_W-1:0] s2_other;
  logic signed [SAMPLE_W-1:0] s2_value;

  logic                       s3_valid;
  logic                       s3_last;
  logic signed [SAMPLE_W-1:0] s3_value;
  logic signed [31:0]         s3_prod;
  logic signed [32:0]         s3_biased;
  logic signed [21:0]         s3_round;
  logic signed [SAMPLE_W-1:0] s3_sat;

  // the whole pipe moves whenever the output register can take a sample
  assign pipe_en = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      SEQ_IDLE: if (pipe_en && head.valid) state_next = SEQ_RUN;
      SEQ_RUN:  if (pipe_en && left == COUNT_W'(1)) state_next = SEQ_IDLE;
      default:  state_next = SEQ_IDLE;
    endcase
  end

  always_comb begin
    pop = 1'b0;
    issue = 1'b0;
    case (state)
      SEQ_IDLE: pop = pipe_en && head.valid;
      SEQ_RUN:  issue = pipe_en;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
      left <= '0;
      phase <= '0;
    end else begin
      state <= state_next;
      if (pop) begin
        left <= head.count;
      end else if (issue) begin
        left <= left - 1'b1;
        phase <= phase + cfg.phase_step;
      end
    end
  end

  // issue stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pipe_en) begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_phase <= phase;
      s1_last <= (left == COUNT_W'(1));
    end
  end

  // odd quadrants read the table mirrored
  always_comb begin
    if (s1_phase[30]) begin
      s1_idx = IDX_W'(QUARTER) - {1'b0, s1_phase[29 -: SINE_TABLE_BITS]};
    end else begin
      s1_idx = {1'b0, s1_phase[29 -: SINE_TABLE_BITS]};
    end
    case (cfg.waveform)
      WAVE_SINE:   s1_other = '0;
      WAVE_SQUARE: s1_other = (s1_phase > 32'h8000_0000) ? ONE_Q11 : -ONE_Q11;
      default:     s1_other = $signed({5'd0, s1_phase[31:21]});
    endcase
  end

  // table stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (pipe_en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s2_last <= s1_last;
      s2_sine <= (cfg.waveform == WAVE_SINE);
      s2_neg <= s1_phase[31];
      s2_rom <= sine_rom[s1_idx];
      s2_other <= s1_other;
    end
  end

  always_comb begin
    if (!s2_sine) begin
      s2_value = s2_other;
    end else if (s2_neg) begin
      s2_value = -$signed({4'd0, s2_rom});
    end else begin
      s2_value = $signed({4'd0, s2_rom});
    end
  end

  // gain stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (pipe_en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s3_last <= s2_last;
      s3_value <= s2_value;
      s3_prod <= s2_value * cfg.scale_gain;
    end
  end

  // round half up, then clamp to 16 bits
  always_comb begin
    s3_biased = 33'(s3_prod) + 33'sd1024;
    s3_round = s3_biased[32:11];
    if (s3_round > 22'sd32767) begin
      s3_sat = 16'sd32767;
    end else if (s3_round < -22'sd32768) begin
      s3_sat = -16'sd32768;
    end else begin
      s3_sat = s3_round[SAMPLE_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pipe_en) begin
      m_tvalid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      m_tdata <= cfg.apply_scale ? s3_sat : s3_value;
      m_tlast <= s3_last;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/multi_waveform_phase_generator.sv -----
// multi-waveform phase generator: a phase-accumulator oscillator giving bursts
// of signed q4.11 samples (sine from a quarter-wave table, square or ramp),
// optionally scaled by a q4.11 gain with rounding and saturation.
// slave stream: one transfer is one request, s_tdata[6:0] = sample count;
// zero asks for nothing, counts above MAX_BURST are cut to MAX_BURST.
// master stream: one transfer per sample, m_tdata = sample, m_tlast marks the
// final sample of the burst.
// apb port: waveform, phase step, scale enable and gain at 0x0, 0x4, 0x8, 0xc;
// write them only while no burst is in flight.
// with the sequencer idle, the first sample of a request goes from the queue through
// the sequencer and the issue, table, gain and output registers to m_tvalid.
// the sequencer issues one sample per cycle while the pipeline is not held, and
// returns to idle after each request to pull the next one from the queue.
// a two-entry request queue lets new requests arrive while a burst runs.
// while a sample waits on m_tready the whole sample pipeline holds, the phase does not
// advance and nothing is lost; s_tready drops once the queue is full.
// reset clears the phase, the queue and the pipeline and restores the
// registers (gain 1.0, sine, step zero, scaling off).
`default_nettype none

module multi_waveform_phase_generator #(
  parameter int MAX_BURST = mwpg_pkg::MAX_BURST_DEF,
  parameter int SINE_TABLE_BITS = mwpg_pkg::SINE_TABLE_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [7:0]                          s_tdata,   // [6:0] sample_count
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [mwpg_pkg::SAMPLE_W-1:0]            m_tdata,   // [15:0] sample_value
  output logic                                     m_tlast,   // last_sample
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [mwpg_pkg::ADDR_W-1:0]         paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);
  import mwpg_pkg::*;

  cfg_t cfg;
  req_t push;
  req_t head;
  logic queue_full;
  logic pop;
  logic signed [SAMPLE_W-1:0] sample;

  mwpg_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mwpg_front #(
    .MAX_BURST (MAX_BURST)
  ) u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .queue_full (queue_full),
    .push       (push)
  );

  mwpg_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (queue_full),
    .pop  (pop),
    .head (head)
  );

  mwpg_back #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (sample),
    .m_tlast  (m_tlast)
  );

  assign m_tdata = sample;

endmodule

`default_nettype wire

// ----- rtl/mwpg_checker.sv -----
`default_nettype none

module mwpg_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        m_tvalid,
  input wire logic                        m_tready,
  input wire logic [mwpg_pkg::SAMPLE_W-1:0] m_tdata,
  input wire logic                        m_tlast,
  input wire logic                        psel,
  input wire logic                        penable,
  input wire logic                        pwrite,
  input wire logic [mwpg_pkg::ADDR_W-1:0] paddr,
  input wire logic [31:0]                 pwdata,
  input wire logic [31:0]                 prdata
);
  import mwpg_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("sample presented right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled sample changed or dropped");

  a_gain_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) && psel && !pwrite && paddr[3:2] == REG_SCALE_GAIN |-> prdata == 32'd2048)
    else $error("gain register not at unity after reset");

  a_step_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && paddr[3:2] == REG_PHASE_STEP
    ##1 psel && !pwrite && paddr[3:2] == REG_PHASE_STEP |-> prdata == $past(pwdata))
    else $error("phase step reads back wrong");

endmodule

bind multi_waveform_phase_generator mwpg_checker u_mwpg_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .psel     (psel),
  .penable  (penable),
  .pwrite   (pwrite),
  .paddr    (paddr),
  .pwdata   (pwdata),
  .prdata   (prdata)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none

module tb_top;
  import mwpg_pkg::*;

  localparam int TABLE_BITS = SINE_TABLE_BITS_DEF;
  localparam int QUARTER = 1 << TABLE_BITS;
  localparam int BURST_CAP = MAX_BURST_DEF;
  localparam int RANDOM_ITEMS = 400;
  localparam int DRAIN_CYCLES = 24;
  localparam longint CYCLE_LIMIT = 10_000_000;
  localparam logic [1:0] WAVE_SPARE = 2'd3;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       last;
  } sample_t;

  typedef struct packed {
    logic [1:0]                 wave;
    logic [31:0]                step;
    logic                       scale_on;
    logic [SAMPLE_W-1:0]        gain;
    logic [COUNT_W-1:0]         count;
    logic                       typed;
    logic signed [SAMPLE_W-1:0] typed_val;
  } probe_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata = 8'd0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [SAMPLE_W-1:0] m_tdata;
  logic                m_tlast;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [31:0]         pwdata = 32'd0;
  logic [31:0]         prdata;
  logic                pready;

  // predictor copy of the registers and the phase
  logic [1:0]                 cur_wave = WAVE_SINE;
  logic [31:0]                cur_step = 32'd0;
  logic                       cur_scale = 1'b0;
  logic signed [SAMPLE_W-1:0] cur_gain = GAIN_RESET;
  logic [31:0]                phase_acc = 32'd0;
  int                         quarter_wave [QUARTER+1];

  sample_t samples_due [$];
  probe_t  directed_rows [20];

  bit     tx_steady = 1'b0;
  bit     rx_steady = 1'b0;
  int     rx_hold = 0;
  int     fail_count = 0;
  int     requests_sent = 0;
  int     samples_checked = 0;
  int     settings_used = 0;
  int     wave_hits [4] = '{0, 0, 0, 0};
  longint cycle_count = 0;

  multi_waveform_phase_generator i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [6:0] sample_count, [7] zero
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [15:0] sample_value
    .m_tlast  (m_tlast),   // last_sample
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // quarter-wave level k in q11, taylor series in q30 rounded half up
  function automatic int quarter_level(input int unsigned k);
    longint unsigned ang;
    longint unsigned ang_sq;
    longint unsigned term;
    longint unsigned plus;
    longint unsigned minus;
    longint unsigned total;
    longint unsigned lvl;
    longint unsigned divisor;
    ang = (HALF_PI_Q30 * 64'(k)) >> TABLE_BITS;
    ang_sq = (ang * ang) >> 30;
    term = ang;
    plus = ang;
    minus = 64'd0;
    for (int n = 1; n <= 6; n++) begin
      divisor = 64'((2 * n) * (2 * n + 1));
      term = ((term * ang_sq) >> 30) / divisor;
      if (n % 2 == 1) begin
        minus = minus + term;
      end else begin
        plus = plus + term;
      end
    end
    total = (plus > minus) ? plus - minus : 64'd0;
    lvl = (total * 64'd2048 + (64'd1 << 29)) >> 30;
    if (lvl > 64'd2048) begin
      lvl = 64'd2048;
    end
    return int'(lvl);
  endfunction

  function automatic logic [SAMPLE_W-1:0] sample_at(input logic [31:0] p);
    int unsigned idx;
    int          level;
    longint      prod;
    idx = (p >> (30 - TABLE_BITS)) & (QUARTER - 1);
    case (cur_wave)
      WAVE_SINE: begin
        level = p[30] ? quarter_wave[QUARTER - idx] : quarter_wave[idx];
        if (p[31]) begin
          level = -level;
        end
      end
      // exactly one half counts as the low level
      WAVE_SQUARE: level = (p > 32'h8000_0000) ? int'(ONE_Q11) : -int'(ONE_Q11);
      default: level = int'(p >> 21);
    endcase
    if (cur_scale) begin
      prod = (longint'(level) * longint'(cur_gain) + 64'sd1024) >>> 11;
      if (prod > 64'sd32767) begin
        prod = 64'sd32767;
      end else if (prod < -64'sd32768) begin
        prod = -64'sd32768;
      end
      level = int'(prod);
    end
    return level[SAMPLE_W-1:0];
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int idle_gap(input bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 96) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [COUNT_W-1:0] request_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      return '0;
    end else if (r < 8) begin
      return COUNT_W'($urandom_range(BURST_CAP + 1, (1 << COUNT_W) - 1));
    end else if (r < 16) begin
      return COUNT_W'(BURST_CAP);
    end else if (r < 30) begin
      return COUNT_W'($urandom_range(17, BURST_CAP - 1));
    end
    return COUNT_W'($urandom_range(1, 16));
  endfunction

  task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] got,
                                 input logic [SAMPLE_W-1:0] want);
    fail_count++;
    $display("mismatch on %s at sample %0d: got %0d, want %0d", what, samples_checked,
             $signed(got), $signed(want));
  endtask

  task automatic push_request(input logic [COUNT_W-1:0] count, input logic typed,
                              input logic signed [SAMPLE_W-1:0] typed_val);
    int      bursts;
    int      gap;
    sample_t due;
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, count};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bursts = (count > BURST_CAP) ? BURST_CAP : int'(count);
    for (int j = 0; j < bursts; j++) begin
      due.value = typed ? typed_val : sample_at(phase_acc);
      due.last = (j == bursts - 1);
      phase_acc = phase_acc + cur_step;
      samples_due.push_back(due);
    end
    requests_sent++;
    wave_hits[cur_wave]++;
    gap = idle_gap(tx_steady);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      s_tdata <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // zero-length requests leave nothing to wait for, so let the pipeline run dry
  task automatic wait_idle();
    int ready_cycles;
    s_tvalid <= 1'b0;
    ready_cycles = 0;
    while (samples_due.size() != 0) @(posedge clk);
    while (ready_cycles < DRAIN_CYCLES) begin
      @(posedge clk);
      if (m_tready) begin
        ready_cycles++;
      end
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_WAVEFORM:    cur_wave = data[1:0];
      REG_PHASE_STEP:  cur_step = data;
      REG_APPLY_SCALE: cur_scale = data[0];
      REG_SCALE_GAIN:  cur_gain = data[SAMPLE_W-1:0];
      default: ;
    endcase
  endtask

  // junk in the unused upper bits must be dropped by the block
  task automatic load_settings(input logic [1:0] wave, input logic [31:0] step,
                               input logic scale_on, input logic [SAMPLE_W-1:0] gain,
                               input logic junk_on);
    logic [31:0] hi;
    hi = junk_on ? $urandom : 32'd0;
    wait_idle();
    write_reg(REG_WAVEFORM, {hi[31:2], wave});
    write_reg(REG_PHASE_STEP, step);
    write_reg(REG_APPLY_SCALE, {hi[31:1], scale_on});
    write_reg(REG_SCALE_GAIN, {hi[31:16], gain});
    psel <= 1'b0;
    penable <= 1'b0;
    settings_used++;
  endtask

  always @(posedge clk) begin : rx_side
    sample_t due;
    if (!rst && m_tvalid && m_tready) begin
      if (samples_due.size() == 0) begin
        report_mismatch("sample with nothing pending", m_tdata, '0);
      end else begin
        due = samples_due.pop_front();
        if (m_tdata !== due.value) begin
          report_mismatch("sample_value", m_tdata, due.value);
        end
        if (m_tlast !== due.last) begin
          report_mismatch("last_sample", SAMPLE_W'(m_tlast), SAMPLE_W'(due.last));
        end
        samples_checked++;
      end
    end
    if (rx_hold != 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else begin
      rx_hold = ($urandom_range(0, 2) == 0) ? idle_gap(rx_steady) : 0;
      m_tready <= (rx_hold == 0);
      if (rx_hold != 0) begin
        rx_hold--;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples still pending", cycle_count,
               samples_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    probe_t           row;
    int               sent_random;
    int               phase_left;
    logic [COUNT_W-1:0] cnt;
    logic [31:0]      step_pick;
    logic [SAMPLE_W-1:0] gain_pick;

    // wave, step, scale on, gain, count, typed, typed value
    directed_rows = '{
      '{WAVE_SINE,   32'h0000_0000, 1'b0, 16'h0800, 7'd1,   1'b1, 16'sd0},
      '{WAVE_SINE,   32'h0000_0000, 1'b0, 16'h0800, 7'd0,   1'b0, 16'sd0},
      '{WAVE_SINE,   32'h0000_0000, 1'b0, 16'h0800, 7'd64,  1'b1, 16'sd0},
      '{WAVE_SINE,   32'h0000_0000, 1'b0, 16'h0800, 7'd127, 1'b1, 16'sd0},
      '{WAVE_SQUARE, 32'h0000_0000, 1'b0, 16'h0800, 7'd1,   1'b1, -16'sd2048},
      '{WAVE_RAMP,   32'h0000_0000, 1'b0, 16'h0800, 7'd1,   1'b1, 16'sd0},
      '{WAVE_SQUARE, 32'h0000_0000, 1'b1, 16'h8000, 7'd2,   1'b1, 16'sd32767},
      '{WAVE_SQUARE, 32'h0000_0000, 1'b1, 16'h7FFF, 7'd1,   1'b1, -16'sd32767},
      '{WAVE_SQUARE, 32'h0000_0000, 1'b1, 16'h0000, 7'd1,   1'b1, 16'sd0},
      '{WAVE_SQUARE, 32'h0000_0000, 1'b0, 16'hFFFF, 7'd1,   1'b1, -16'sd2048},
      '{WAVE_SINE,   32'h4000_0000, 1'b0, 16'h0800, 7'd9,   1'b0, 16'sd0},
      '{WAVE_SQUARE, 32'h8000_0000, 1'b0, 16'h0800, 7'd4,   1'b0, 16'sd0},
      '{WAVE_SQUARE, 32'h7FFF_FFFF, 1'b0, 16'h0800, 7'd6,   1'b0, 16'sd0},
      '{WAVE_RAMP,   32'hFFFF_FFFF, 1'b0, 16'h0800, 7'd8,   1'b0, 16'sd0},
      '{WAVE_SPARE,  32'h0123_4567, 1'b0, 16'h0800, 7'd8,   1'b0, 16'sd0},
      '{WAVE_SINE,   32'h0040_0000, 1'b1, 16'h7FFF, 7'd24,  1'b0, 16'sd0},
      '{WAVE_SINE,   32'hFFC0_0000, 1'b1, 16'h8000, 7'd24,  1'b0, 16'sd0},
      '{WAVE_RAMP,   32'h0020_0000, 1'b1, 16'h7FFF, 7'd16,  1'b0, 16'sd0},
      '{WAVE_SINE,   32'h0000_0001, 1'b0, 16'h0800, 7'd1,   1'b0, 16'sd0},
      '{WAVE_SINE,   32'h8000_0000, 1'b1, 16'h0800, 7'd5,   1'b0, 16'sd0}
    };
    for (int k = 0; k <= QUARTER; k++) begin
      quarter_wave[k] = quarter_level(k);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // the first rows rely on the reset register values and a phase of zero
    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.wave != cur_wave || row.step != cur_step || row.scale_on != cur_scale ||
          row.gain != cur_gain) begin
        load_settings(row.wave, row.step, row.scale_on, row.gain, 1'b0);
      end
      push_request(row.count, row.typed, row.typed_val);
    end

    sent_random = 0;
    while (sent_random < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       step_pick = 32'h7FFF_FFFF;
        1:       step_pick = 32'h8000_0000;
        2:       step_pick = 32'($urandom_range(1, 1 << 24));
        3:       step_pick = -32'($urandom_range(1, 1 << 24));
        default: step_pick = $urandom;
      endcase
      case ($urandom_range(0, 4))
        0:       gain_pick = 16'h7FFF;
        1:       gain_pick = 16'h8000;
        2:       gain_pick = GAIN_RESET;
        default: gain_pick = 16'($urandom);
      endcase
      load_settings(2'($urandom_range(0, 3)), step_pick, 1'($urandom_range(0, 1)),
                    gain_pick, 1'($urandom_range(0, 1)));
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      phase_left = $urandom_range(15, 40);
      while (phase_left > 0 && sent_random < RANDOM_ITEMS) begin
        cnt = request_size();
        push_request(cnt, 1'b0, '0);
        if (cnt != 0) begin
          sent_random++;
          phase_left--;
        end
      end
    end

    tx_steady = 1'b0;
    rx_steady = 1'b0;
    wait_idle();

    $display("%0d requests, %0d samples checked, %0d register settings loaded",
             requests_sent, samples_checked, settings_used);
    $display("requests per waveform code: sine %0d, square %0d, ramp %0d, spare %0d",
             wave_hits[WAVE_SINE], wave_hits[WAVE_SQUARE], wave_hits[WAVE_RAMP],
             wave_hits[WAVE_SPARE]);
    if (fail_count == 0 && samples_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
